// ----- design/cdt_pkg.sv -----
// Shared constants for the countdown timer core: request kinds, register map, control layout.
package cdt_pkg;

   // Default widths of the two prescalers
   localparam int PRESCALE_BITS_DEFAULT      = 10;
   localparam int FREE_PRESCALE_BITS_DEFAULT = 8;

   // Divisor after reset (divide by 126)
   localparam logic [31:0] PRESCALE_DIV_RESET = 32'h0000_007D;

   // Request kinds carried on tuser
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // Register word indexes
   localparam logic [3:0] REG_LOAD     = 4'd0;
   localparam logic [3:0] REG_VALUE    = 4'd1;
   localparam logic [3:0] REG_CONTROL  = 4'd2;
   localparam logic [3:0] REG_CLEAR    = 4'd3;
   localparam logic [3:0] REG_OVERFLOW = 4'd4;
   localparam logic [3:0] REG_IRQ      = 4'd5;
   localparam logic [3:0] REG_RELOAD   = 4'd6;
   localparam logic [3:0] REG_PRESCALE = 4'd7;
   localparam logic [3:0] REG_FREE     = 4'd8;

   // Control register bit positions as seen on the bus
   localparam int CTL_MODE32_BIT  = 1;
   localparam int CTL_IRQEN_BIT   = 5;
   localparam int CTL_ENABLE_BIT  = 7;
   localparam int CTL_DEBUG_BIT   = 8;
   localparam int CTL_FREEEN_BIT  = 9;
   localparam int CTL_FREEPS_LSB  = 16;

   // Stream widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

endpackage

// ----- design/countdown_timer_peripheral_core.sv -----
// Countdown timer core: prescaled down counter, overflow flag and free-running counter.
// A request passes through an input register and then a response register.
// Throughput: one request per cycle; ready falls only while the response register is full
// and the downstream side holds off.
// Reset (synchronous, active high) clears all timer state, sets the prescale divisor to
// its default and empties both pipeline registers.
module countdown_timer_peripheral_core #(
   parameter int PRESCALE_BITS      = cdt_pkg::PRESCALE_BITS_DEFAULT,
   parameter int FREE_PRESCALE_BITS = cdt_pkg::FREE_PRESCALE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [3:0] reg_index, [35:4] write_data, [39:36] zero
   input  logic [cdt_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [1:0] action
   input  logic [cdt_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] read_data, [32] irq_line, [33] overflow_flag, [39:34] zero
   output logic [cdt_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import cdt_pkg::*;

   localparam logic [PRESCALE_BITS-1:0] DIV_RESET = PRESCALE_BITS'(PRESCALE_DIV_RESET);

   // Input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_action_ff;
   logic [3:0]  s1_index_ff;
   logic [31:0] s1_data_ff;

   // Timer state
   logic [31:0]                   count_ff, count_in;
   logic [31:0]                   load_ff, load_in;
   logic [31:0]                   reload_ff, reload_in;
   logic [PRESCALE_BITS-1:0]      div_ff, div_in;
   logic [PRESCALE_BITS-1:0]      phase_ff, phase_in;
   logic                          mode32_ff, mode32_in;
   logic                          irq_en_ff, irq_en_in;
   logic                          enable_ff, enable_in;
   logic                          debug_ff, debug_in;
   logic                          free_en_ff, free_en_in;
   logic [FREE_PRESCALE_BITS-1:0] free_ps_ff, free_ps_in;
   logic                          ovf_ff, ovf_in;
   logic [31:0]                   free_count_ff, free_count_in;
   logic [FREE_PRESCALE_BITS-1:0] free_phase_ff, free_phase_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_rdata_ff, rsp_rdata_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   logic        out_free, s1_adv, req_take;
   logic        divided;
   logic [15:0] low16;
   logic [31:0] ctrl_rd, read_val;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, rsp_irq_ff, rsp_rdata_ff};

   always_comb begin
      ctrl_rd                                     = '0;
      ctrl_rd[CTL_MODE32_BIT]                     = mode32_ff;
      ctrl_rd[CTL_IRQEN_BIT]                      = irq_en_ff;
      ctrl_rd[CTL_ENABLE_BIT]                     = enable_ff;
      ctrl_rd[CTL_DEBUG_BIT]                      = debug_ff;
      ctrl_rd[CTL_FREEEN_BIT]                     = free_en_ff;
      ctrl_rd[CTL_FREEPS_LSB +: FREE_PRESCALE_BITS] = free_ps_ff;
   end

   always_comb begin
      case (s1_index_ff)
         REG_LOAD:     read_val = load_ff;
         REG_VALUE:    read_val = count_ff;
         REG_CONTROL:  read_val = ctrl_rd;
         REG_OVERFLOW: read_val = {31'd0, ovf_ff};
         REG_IRQ:      read_val = {31'd0, ovf_ff && irq_en_ff};
         REG_RELOAD:   read_val = reload_ff;
         REG_PRESCALE: read_val = 32'(div_ff);
         REG_FREE:     read_val = free_count_ff;
         default:      read_val = '0;
      endcase
   end

   assign divided = phase_ff >= div_ff;
   assign low16   = count_ff[15:0];

   always_comb begin
      count_in      = count_ff;
      load_in       = load_ff;
      reload_in     = reload_ff;
      div_in        = div_ff;
      phase_in      = phase_ff;
      mode32_in     = mode32_ff;
      irq_en_in     = irq_en_ff;
      enable_in     = enable_ff;
      debug_in      = debug_ff;
      free_en_in    = free_en_ff;
      free_ps_in    = free_ps_ff;
      ovf_in        = ovf_ff;
      free_count_in = free_count_ff;
      free_phase_in = free_phase_ff;
      rsp_rdata_in  = '0;

      if (s1_adv) begin
         case (s1_action_ff)
            ACT_TICK: begin
               phase_in = divided ? '0 : phase_ff + 1'b1;
               if (divided && enable_ff) begin
                  if (mode32_ff) begin
                     if (count_ff == '0) begin
                        count_in = reload_ff;
                        ovf_in   = 1'b1;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end else begin
                     // sixteen-bit mode: upper half drops to zero
                     if (low16 == '0) begin
                        count_in = {16'd0, reload_ff[15:0]};
                        ovf_in   = 1'b1;
                     end else begin
                        count_in = {16'd0, low16 - 1'b1};
                     end
                  end
               end
               if (free_en_ff) begin
                  if (free_phase_ff >= free_ps_ff) begin
                     free_phase_in = '0;
                     free_count_in = free_count_ff + 1'b1;
                  end else begin
                     free_phase_in = free_phase_ff + 1'b1;
                  end
               end
            end
            ACT_WRITE: begin
               case (s1_index_ff)
                  REG_LOAD: begin
                     count_in = s1_data_ff;
                     load_in  = s1_data_ff;
                  end
                  REG_CONTROL: begin
                     mode32_in  = s1_data_ff[CTL_MODE32_BIT];
                     irq_en_in  = s1_data_ff[CTL_IRQEN_BIT];
                     enable_in  = s1_data_ff[CTL_ENABLE_BIT];
                     debug_in   = s1_data_ff[CTL_DEBUG_BIT];
                     free_en_in = s1_data_ff[CTL_FREEEN_BIT];
                     free_ps_in = s1_data_ff[CTL_FREEPS_LSB +: FREE_PRESCALE_BITS];
                  end
                  REG_CLEAR:    ovf_in    = 1'b0;
                  REG_RELOAD:   reload_in = s1_data_ff;
                  REG_PRESCALE: div_in    = s1_data_ff[PRESCALE_BITS-1:0];
                  default:      ;
               endcase
            end
            ACT_READ: rsp_rdata_in = read_val;
            default:  ;
         endcase
      end
   end

   assign rsp_irq_in   = ovf_in && irq_en_in;
   assign rsp_ovf_in   = ovf_in;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         load_ff       <= '0;
         reload_ff     <= '0;
         div_ff        <= DIV_RESET;
         phase_ff      <= '0;
         mode32_ff     <= 1'b0;
         irq_en_ff     <= 1'b0;
         enable_ff     <= 1'b0;
         debug_ff      <= 1'b0;
         free_en_ff    <= 1'b0;
         free_ps_ff    <= '0;
         ovf_ff        <= 1'b0;
         free_count_ff <= '0;
         free_phase_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         count_ff      <= count_in;
         load_ff       <= load_in;
         reload_ff     <= reload_in;
         div_ff        <= div_in;
         phase_ff      <= phase_in;
         mode32_ff     <= mode32_in;
         irq_en_ff     <= irq_en_in;
         enable_ff     <= enable_in;
         debug_ff      <= debug_in;
         free_en_ff    <= free_en_in;
         free_ps_ff    <= free_ps_in;
         ovf_ff        <= ovf_in;
         free_count_ff <= free_count_in;
         free_phase_ff <= free_phase_in;
      end
   end

   // Payload registers: capture a request on accept, a response on advance
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_tuser[1:0];
         s1_index_ff  <= req_tdata[3:0];
         s1_data_ff   <= req_tdata[35:4];
      end
      if (s1_adv) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_irq_ff   <= rsp_irq_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   // Overflow only rises as the result of a tick
   assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && !$past(ovf_ff)) |-> $past(s1_adv && s1_action_ff == ACT_TICK))
      else $error("overflow set without a tick");

   // Free counter moves only while enabled
   assert property (@(posedge clock) disable iff (reset)
      (free_count_ff != $past(free_count_ff)) |-> $past(free_en_ff))
      else $error("free counter moved while disabled");

   // A reported interrupt always has its overflow flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_irq_ff || rsp_ovf_ff))
      else $error("irq reported without overflow");

   // An advancing request always lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("request advanced but no response");

endmodule

// ----- sim/tb_countdown_timer_peripheral_core.sv -----
// Self-checking testbench for the countdown timer core: directed and random bus requests.
`timescale 1ns / 100ps

module tb_countdown_timer_peripheral_core;
   import cdt_pkg::*;

   localparam logic [1:0] ACT_NONE           = 2'd3;
   localparam logic [3:0] IDX_UNMAPPED_FIRST = 4'd9;
   localparam logic [3:0] IDX_UNMAPPED_LAST  = 4'd15;
   localparam int         CYCLE_LIMIT        = 400000;
   localparam int         HOLD_CYCLES        = 300;
   localparam int         PRE_W              = PRESCALE_BITS_DEFAULT;
   localparam int         FREE_W             = FREE_PRESCALE_BITS_DEFAULT;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
      logic        overflow;
   } response_type;

   // Timer state tracker: predicts one response per accepted request
   class timer_tracker_type;
      logic [31:0]       counter;
      logic [31:0]       load_reg;
      logic [31:0]       reload_reg;
      logic [PRE_W-1:0]  divisor;
      logic [PRE_W-1:0]  phase;
      logic              mode32, irq_en, enable, debug, free_en;
      logic [FREE_W-1:0] free_div;
      logic [FREE_W-1:0] free_phase;
      logic [31:0]       free_counter;
      logic              pending;
      response_type      expected_responses[$];
      int                mismatches, ticks, writes, reads, wraps;

      function new();
         counter = '0; load_reg = '0; reload_reg = '0;
         divisor = PRESCALE_DIV_RESET[PRE_W-1:0];
         phase = '0;
         mode32 = 0; irq_en = 0; enable = 0; debug = 0; free_en = 0;
         free_div = '0; free_phase = '0; free_counter = '0; pending = 0;
         mismatches = 0; ticks = 0; writes = 0; reads = 0; wraps = 0;
      endfunction

      function void advance_tick();
         logic divided;
         divided = 0;
         if (phase >= divisor) begin
            phase = '0;
            divided = 1;
         end else begin
            phase = phase + 1'b1;
         end
         if (divided && enable) begin
            if (mode32) begin
               if (counter == 0) begin
                  counter = reload_reg;
                  pending = 1;
                  wraps++;
               end else begin
                  counter = counter - 1;
               end
            end else begin
               // 16-bit mode: upper half is cleared on every divided tick while enabled
               if (counter[15:0] == 0) begin
                  counter = {16'h0, reload_reg[15:0]};
                  pending = 1;
                  wraps++;
               end else begin
                  counter = {16'h0, counter[15:0] - 16'd1};
               end
            end
         end
         if (free_en) begin
            if (free_phase >= free_div) begin
               free_phase = '0;
               free_counter = free_counter + 1;
            end else begin
               free_phase = free_phase + 1'b1;
            end
         end
      endfunction

      function logic [31:0] control_view();
         logic [31:0] v;
         v = '0;
         v[CTL_MODE32_BIT] = mode32;
         v[CTL_IRQEN_BIT]  = irq_en;
         v[CTL_ENABLE_BIT] = enable;
         v[CTL_DEBUG_BIT]  = debug;
         v[CTL_FREEEN_BIT] = free_en;
         v[CTL_FREEPS_LSB +: FREE_W] = free_div;
         return v;
      endfunction

      function void bus_write(logic [3:0] idx, logic [31:0] d);
         case (idx)
            REG_LOAD: begin
               counter  = d;
               load_reg = d;
            end
            REG_CONTROL: begin
               mode32   = d[CTL_MODE32_BIT];
               irq_en   = d[CTL_IRQEN_BIT];
               enable   = d[CTL_ENABLE_BIT];
               debug    = d[CTL_DEBUG_BIT];
               free_en  = d[CTL_FREEEN_BIT];
               free_div = d[CTL_FREEPS_LSB +: FREE_W];
            end
            REG_CLEAR:    pending = 0;
            REG_RELOAD:   reload_reg = d;
            REG_PRESCALE: divisor = d[PRE_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] bus_read(logic [3:0] idx);
         case (idx)
            REG_LOAD:     return load_reg;
            REG_VALUE:    return counter;
            REG_CONTROL:  return control_view();
            REG_OVERFLOW: return {31'h0, pending};
            REG_IRQ:      return {31'h0, pending & irq_en};
            REG_RELOAD:   return reload_reg;
            REG_PRESCALE: return {{(32-PRE_W){1'b0}}, divisor};
            REG_FREE:     return free_counter;
            default:      return '0;
         endcase
      endfunction

      function void accept_request(logic [1:0] kind, logic [3:0] idx, logic [31:0] d);
         response_type r;
         r.read_data = '0;
         case (kind)
            ACT_TICK: begin
               advance_tick();
               ticks++;
            end
            ACT_WRITE: begin
               bus_write(idx, d);
               writes++;
            end
            ACT_READ: begin
               r.read_data = bus_read(idx);
               reads++;
            end
            default: ;
         endcase
         r.irq      = pending & irq_en;
         r.overflow = pending;
         expected_responses.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task match_response(logic [RSP_TDATA_W-1:0] word);
         response_type e;
         if (expected_responses.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding", word));
            return;
         end
         e = expected_responses.pop_front();
         if (word[31:0] !== e.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", word[31:0], e.read_data));
         if (word[32] !== e.irq)
            report_mismatch($sformatf("irq_line %b, expected %b", word[32], e.irq));
         if (word[33] !== e.overflow)
            report_mismatch($sformatf("overflow_flag %b, expected %b", word[33], e.overflow));
      endtask

      function int outstanding();
         return expected_responses.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   timer_tracker_type tracker;
   int                sender_idle_pct;
   int                receiver_stall_pct;
   logic              hold_request = 1'b0;
   logic              hold_done = 1'b0;
   int                hold_left = 0;
   int                cycle_count = 0;

   countdown_timer_peripheral_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Downstream side: random stalls, or one long hold-off counted down here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES - 1;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Track requests and check responses on their handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.accept_request(req_tuser, req_tdata[3:0], req_tdata[35:4]);
         if (rsp_tvalid && rsp_tready)
            tracker.match_response(rsp_tdata);
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [3:0] idx,
                               input logic [31:0] d);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'h0, d, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      // let the tracker note the last accepted request first
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int          pick;
      logic [1:0]  kind;
      logic [3:0]  idx;
      logic [31:0] d;
      pick = $urandom_range(99);
      if (pick < 55)      kind = ACT_TICK;
      else if (pick < 78) kind = ACT_WRITE;
      else if (pick < 97) kind = ACT_READ;
      else                kind = ACT_NONE;
      idx = ($urandom_range(19) == 0) ?
            4'($urandom_range(IDX_UNMAPPED_LAST, IDX_UNMAPPED_FIRST)) :
            4'($urandom_range(REG_FREE));
      d = $urandom;
      if (kind == ACT_WRITE) begin
         case (idx)
            REG_PRESCALE: if ($urandom_range(9) != 0) d = $urandom_range(6);
            REG_LOAD, REG_RELOAD: begin
               pick = $urandom_range(5);
               if (pick < 4)       d = $urandom_range(12);
               else if (pick == 4) d[15:0] = 16'($urandom_range(5));
            end
            REG_CONTROL: begin
               // keep the timer running and the free prescaler short most of the time
               if ($urandom_range(3) != 0) d[CTL_ENABLE_BIT] = 1'b1;
               if ($urandom_range(3) != 0) d[CTL_FREEPS_LSB +: FREE_W] = FREE_W'($urandom_range(3));
            end
            REG_CLEAR: if ($urandom_range(1) == 0) idx = REG_OVERFLOW;
            default: ;
         endcase
      end
      send_request(kind, idx, d);
   endtask

   initial begin
      tracker            = new();
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = ACT_TICK;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset values, register extremes, 16- and 32-bit wrap, odd indexes
      send_request(ACT_READ,  REG_CONTROL,  32'h0);
      send_request(ACT_READ,  REG_PRESCALE, 32'hFFFF_FFFF);
      send_request(ACT_WRITE, REG_PRESCALE, 32'hFFFF_FFFF);
      send_request(ACT_READ,  REG_PRESCALE, 32'h0);
      send_request(ACT_WRITE, REG_PRESCALE, 32'h0);
      send_request(ACT_WRITE, REG_RELOAD,   32'h0001_0002);
      send_request(ACT_WRITE, REG_LOAD,     32'hFFFF_0001);
      send_request(ACT_READ,  REG_VALUE,    32'h0);
      send_request(ACT_WRITE, REG_CONTROL,  32'h0000_02A0);
      repeat (3) send_request(ACT_TICK, REG_LOAD, 32'h0);
      send_request(ACT_READ,  REG_IRQ,      32'h0);
      send_request(ACT_WRITE, REG_VALUE,    32'hFFFF_FFFF);
      send_request(ACT_WRITE, REG_FREE,     32'hFFFF_FFFF);
      send_request(ACT_READ,  REG_CLEAR,    32'h0);
      send_request(ACT_WRITE, REG_CLEAR,    32'h0);
      send_request(ACT_WRITE, IDX_UNMAPPED_LAST,  32'hFFFF_FFFF);
      send_request(ACT_READ,  IDX_UNMAPPED_FIRST, 32'h0);
      send_request(ACT_NONE,  REG_LOAD,     32'hFFFF_FFFF);
      send_request(ACT_WRITE, REG_CONTROL,  32'hFFFF_FFFF);
      send_request(ACT_WRITE, REG_LOAD,     32'h0);
      // raise the divisor, let the phase run, then drop the divisor below it
      send_request(ACT_WRITE, REG_PRESCALE, 32'h5);
      repeat (3) send_request(ACT_TICK, REG_LOAD, 32'h0);
      send_request(ACT_WRITE, REG_PRESCALE, 32'h1);
      send_request(ACT_TICK,  REG_LOAD,     32'h0);
      send_request(ACT_READ,  REG_VALUE,    32'h0);
      send_request(ACT_READ,  REG_FREE,     32'h0);
      wait_for_responses();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
         endcase
         repeat (160) random_request();
         if (p == 0) begin
            // hold the response side off long enough to back up the request side
            hold_request <= 1'b1;
            repeat (40) random_request();
         end
         repeat (165) random_request();
         wait_for_responses();
      end

      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.outstanding() != 0)
         tracker.report_mismatch($sformatf("%0d responses never arrived", tracker.outstanding()));

      $display("requests: %0d ticks, %0d writes, %0d reads, plus idle and unmapped accesses",
               tracker.ticks, tracker.writes, tracker.reads);
      $display("counter wrapped %0d times under four handshake pressure profiles; %0d mismatches",
               tracker.wraps, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- countdown_timer_peripheral_core.f -----
design/cdt_pkg.sv
design/countdown_timer_peripheral_core.sv
sim/tb_countdown_timer_peripheral_core.sv
